>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stick-to-wheel block
// Shared checks, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with an explicit failure message
`define SMWA_CHECK_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check with a generic failure message
`define SMWA_CHECK(lbl, prop) \
   `SMWA_CHECK_MSG(lbl, prop, "smwa: internal check failed")

`endif

>>> design/smwa_pkg.sv
// ----------------------------------------------------------------------------
// smwa_pkg
// Types, constants and the arctangent table of the stick-to-wheel block.
// ----------------------------------------------------------------------------
package smwa_pkg;

   // fixed-point setup
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int ANG_ONE         = 1 << ANGLE_FRAC_BITS;
   localparam int DEG90           = 90 * ANG_ONE;
   localparam int DEG180          = 180 * ANG_ONE;
   localparam int DEG360          = 360 * ANG_ONE;
   localparam int Z_FRAC          = 16;
   localparam int RND_SHIFT       = Z_FRAC - ANGLE_FRAC_BITS;
   localparam int Q90             = 90 << Z_FRAC;

   // field widths
   localparam int XY_W       = 16;
   localparam int AXIS_W     = 16;
   localparam int OUT_ANG_W  = 19;
   localparam int TURN_W     = 4;
   localparam int RANGE_W    = 12;
   localparam int DZ_W       = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // internal widths
   localparam int ANG_W   = ANGLE_FRAC_BITS + 9;
   localparam int THETA_W = ANGLE_FRAC_BITS + 7;
   localparam int TOT_W   = ANGLE_FRAC_BITS + 14;
   localparam int HALF_W  = RANGE_W + ANGLE_FRAC_BITS - 1;
   localparam int V_W     = RANGE_W + ANGLE_FRAC_BITS;
   localparam int NUM_W   = V_W + 16;
   localparam int QUO_W   = 16;
   localparam int CX_W    = 27;
   localparam int Z_W     = 25;
   localparam int ZC_W    = 23;
   localparam int CNT_W   = 5;
   localparam int MAXR_W  = 3;
   localparam int MAXR_N  = 6;
   localparam int SQ_W    = 32;
   localparam int LIM_W   = 22;
   localparam int M10K_W  = 46;
   localparam int LSQ_W   = 44;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT      = 2'd2;

   // reset and scaling constants
   localparam logic [RANGE_W-1:0] RANGE_RESET = 12'd900;
   localparam logic [AXIS_W-1:0]  HELD_RESET  = 16'd16385;
   localparam int                 AXIS_MIRROR = 32769;
   localparam int                 STICK_FULL  = 32767;
   localparam int                 PCT_SQ      = 10000;
   localparam int                 LOCK_STEP   = 720;
   localparam int                 LOCK_BIAS   = 360;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_PROD,
      ST_DZONE,
      ST_CORDIC,
      ST_ANGLE,
      ST_TURN,
      ST_NUM,
      ST_DIV,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             square;
      logic             prod;
      logic             dzone;
      logic             cordic;
      logic             angle;
      logic             turn;
      logic             num;
      logic             div;
      logic             done;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dead;
      logic on_axis;
      logic out_free;
   } stat_type;

   // atan(2^-i) in degrees times 2^16
   function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
      logic [21:0] a;
      case (i)
         5'd0:  a = 22'd2949120;
         5'd1:  a = 22'd1740967;
         5'd2:  a = 22'd919879;
         5'd3:  a = 22'd466945;
         5'd4:  a = 22'd234379;
         5'd5:  a = 22'd117304;
         5'd6:  a = 22'd58666;
         5'd7:  a = 22'd29335;
         5'd8:  a = 22'd14668;
         5'd9:  a = 22'd7334;
         5'd10: a = 22'd3667;
         5'd11: a = 22'd1833;
         5'd12: a = 22'd917;
         5'd13: a = 22'd458;
         5'd14: a = 22'd229;
         5'd15: a = 22'd115;
         5'd16: a = 22'd57;
         5'd17: a = 22'd29;
         5'd18: a = 22'd14;
         5'd19: a = 22'd7;
         5'd20: a = 22'd4;
         5'd21: a = 22'd2;
         5'd22: a = 22'd1;
         default: a = 22'd0;
      endcase
      return a;
   endfunction

endpackage

>>> design/smwa_ctrl.sv
// ----------------------------------------------------------------------------
// smwa_ctrl
// Sequencer: steps the datapath through dead-zone test, CORDIC, turn
// tracking and the axis division for one transaction at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smwa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smwa_pkg::stat_type stat,
   output smwa_pkg::cmd_type  cmd
);
   import smwa_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // state and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.idx   = cnt_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_DZONE;
         end
         ST_DZONE: begin
            cmd.dzone = 1'b1;
            cnt_in    = '0;
            if (stat.dead)
               state_in = ST_TURN;
            else if (stat.on_axis)
               state_in = ST_ANGLE;
            else
               state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic = 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1))
               state_in = ST_ANGLE;
            else
               cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = ST_TURN;
         end
         ST_TURN: begin
            cmd.turn = 1'b1;
            state_in = stat.dead ? ST_DONE : ST_NUM;
         end
         ST_NUM: begin
            cmd.num  = 1'b1;
            cnt_in   = CNT_W'(QUO_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (cnt_ff == '0)
               state_in = ST_DONE;
            else
               cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // op strobes sit above the step index in the command word
   `SMWA_CHECK_MSG(a_one_op, $onehot0(cmd[$bits(cmd_type)-1:CNT_W]), "smwa: overlapping ops")
   `SMWA_CHECK(a_div_ends, (cmd.div && cnt_ff == '0) |=> state_ff == ST_DONE)

endmodule

>>> design/smwa_dpath.sv
// ----------------------------------------------------------------------------
// smwa_dpath
// Datapath: settings, dead-zone products, CORDIC vectoring, turn tracking,
// clip, restoring divider for the axis scale and the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smwa_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [smwa_pkg::XY_W-1:0]       req_stick_x,
   input  logic signed [smwa_pkg::XY_W-1:0]       req_stick_y,
   input  logic                                   csr_we,
   input  logic [smwa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [smwa_pkg::CSR_DATA_W-1:0]        csr_data,
   input  smwa_pkg::cmd_type                      cmd,
   output smwa_pkg::stat_type                     stat,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [smwa_pkg::AXIS_W-1:0]            rsp_axis_value,
   output logic signed [smwa_pkg::OUT_ANG_W-1:0]  rsp_wheel_angle,
   output logic signed [smwa_pkg::TURN_W-1:0]     rsp_turn_count,
   output logic                                   rsp_deadzone_hit
);
   import smwa_pkg::*;

   localparam logic signed [TOT_W-1:0] DEG180_T = TOT_W'(DEG180);
   localparam logic signed [TOT_W-1:0] DEG360_T = TOT_W'(DEG360);

   // settings
   logic [RANGE_W-1:0] range_ff;
   logic [DZ_W-1:0]    dz_ff;
   logic               invert_ff;
   // sample and dead-zone products
   logic signed [XY_W-1:0] x_ff, y_ff;
   logic [SQ_W-1:0]        xx_ff, yy_ff;
   logic [LIM_W-1:0]       lim_ff;
   logic [M10K_W-1:0]      m10k_ff;
   logic [LSQ_W-1:0]       limsq_ff;
   // CORDIC
   logic signed [CX_W-1:0] cx_ff, cy_ff, dx, dy;
   logic signed [Z_W-1:0]  z_ff, atan_s;
   // angle and turns
   logic signed [ANG_W-1:0]     cur_ff, cur_in, prev_ff, cur_new_ff, cur_new_in;
   logic signed [TURN_W-1:0]    turn_ff, turn_new_ff, turn_new_in;
   logic signed [OUT_ANG_W-1:0] total_ff, total_in;
   logic [AXIS_W-1:0]           held_ff;
   // divider
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] q_ff, q_in;
   // response
   logic                        rsp_valid_ff;
   logic [AXIS_W-1:0]           axis_ff;
   logic signed [OUT_ANG_W-1:0] ang_out_ff;
   logic signed [TURN_W-1:0]    turn_out_ff;
   logic                        dead_out_ff;

   logic [RANGE_W-1:0]      range_eff;
   logic [HALF_W-1:0]       half;
   logic [V_W:0]            dsr;
   logic                    dead;
   logic [XY_W:0]           abs_x, abs_y;
   logic [ZC_W-1:0]         zc;
   logic [THETA_W-1:0]      theta;
   logic signed [TOT_W-1:0] half_s, cur_x, last_x, base, total_raw, lock_off, v_full;
   logic signed [TURN_W:0]  turns_adj;
   logic [RANGE_W:0]        rp;
   logic [MAXR_W-1:0]       maxr;
   logic [NUM_W:0]          dsh;
   logic [AXIS_W-1:0]       axis_raw;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= RANGE_RESET;
         dz_ff     <= '0;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WHEEL_RANGE: range_ff  <= csr_data[RANGE_W-1:0];
            CSR_DEADZONE:    dz_ff     <= csr_data[DZ_W-1:0];
            CSR_INVERT:      invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // range-derived values
   always_comb begin
      range_eff = (range_ff == '0) ? RANGE_W'(1) : range_ff;
      half      = HALF_W'(range_eff) << (ANGLE_FRAC_BITS - 1);
      half_s    = $signed(TOT_W'(half));
      dsr       = (V_W + 1)'(range_eff) << (ANGLE_FRAC_BITS + 1);
      rp        = (RANGE_W + 1)'(range_eff) + (RANGE_W + 1)'(LOCK_BIAS);
      maxr      = '0;
      for (int k = 1; k <= MAXR_N; k++) begin
         if (rp >= (RANGE_W + 1)'(k * LOCK_STEP))
            maxr = MAXR_W'(k);
      end
   end

   // status
   always_comb begin
      dead          = (M10K_W'(limsq_ff) >= m10k_ff);
      stat.dead     = dead;
      stat.on_axis  = (x_ff == '0) || (y_ff == '0);
      stat.out_free = !rsp_valid_ff || rsp_ready;
      abs_x = x_ff[XY_W-1] ? ((XY_W + 1)'(0) - (XY_W + 1)'(x_ff)) : (XY_W + 1)'(x_ff);
      abs_y = y_ff[XY_W-1] ? ((XY_W + 1)'(0) - (XY_W + 1)'(y_ff)) : (XY_W + 1)'(y_ff);
   end

   // sample capture and dead-zone products
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_stick_x;
         y_ff <= req_stick_y;
      end
      if (cmd.square) begin
         // operands sign-extended so the full square is kept
         xx_ff  <= SQ_W'(x_ff) * SQ_W'(x_ff);
         yy_ff  <= SQ_W'(y_ff) * SQ_W'(y_ff);
         lim_ff <= LIM_W'(dz_ff) * LIM_W'(STICK_FULL);
      end
      if (cmd.prod) begin
         m10k_ff  <= M10K_W'((SQ_W + 1)'(xx_ff) + (SQ_W + 1)'(yy_ff)) * M10K_W'(PCT_SQ);
         limsq_ff <= LSQ_W'(lim_ff) * LSQ_W'(lim_ff);
      end
   end

   // CORDIC vectoring step
   always_comb begin
      dx     = cy_ff >>> cmd.idx;
      dy     = cx_ff >>> cmd.idx;
      atan_s = $signed(Z_W'(atan_q16(cmd.idx)));
   end

   always_ff @(posedge clock) begin
      if (cmd.dzone) begin
         cx_ff <= $signed(CX_W'(abs_y) << 8);
         cy_ff <= $signed(CX_W'(abs_x) << 8);
         z_ff  <= '0;
      end else if (cmd.cordic) begin
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            z_ff  <= z_ff + atan_s;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            z_ff  <= z_ff - atan_s;
         end
      end
   end

   // clamp, round and map the angle to its quadrant
   always_comb begin
      if (z_ff < 0)
         zc = '0;
      else if (z_ff > Z_W'(Q90))
         zc = ZC_W'(Q90);
      else
         zc = ZC_W'(z_ff);
      theta = THETA_W'((zc + ZC_W'(1 << (RND_SHIFT - 1))) >> RND_SHIFT);
      if (x_ff == '0)
         cur_in = (y_ff >= 0) ? '0 : ANG_W'(DEG180);
      else if (y_ff == '0)
         cur_in = (x_ff > 0) ? ANG_W'(DEG90) : -ANG_W'(DEG90);
      else if (x_ff > 0)
         cur_in = (y_ff > 0) ? $signed(ANG_W'(theta))
                             : ANG_W'(DEG180) - $signed(ANG_W'(theta));
      else if (y_ff > 0)
         cur_in = -$signed(ANG_W'(theta));
      else if (theta == '0)
         cur_in = ANG_W'(DEG180);
      else
         cur_in = $signed(ANG_W'(theta)) - ANG_W'(DEG180);
   end

   // turn tracking and clip at the locks
   always_comb begin
      cur_x     = TOT_W'(cur_ff);
      last_x    = TOT_W'(prev_ff);
      turns_adj = (TURN_W + 1)'(turn_ff);
      if (dead) begin
         base = last_x;
      end else begin
         base = cur_x;
         if (cur_x < 0 && cur_x < last_x - DEG180_T)
            turns_adj = turns_adj + (TURN_W + 1)'(1);
         else if (cur_x > 0 && cur_x > last_x + DEG180_T)
            turns_adj = turns_adj - (TURN_W + 1)'(1);
      end
      total_raw   = base + TOT_W'(turns_adj * DEG360_T);
      lock_off    = TOT_W'($signed({1'b0, maxr}) * DEG360_T);
      total_in    = OUT_ANG_W'(total_raw);
      cur_new_in  = ANG_W'(base);
      turn_new_in = TURN_W'(turns_adj);
      if (total_raw > half_s) begin
         total_in    = OUT_ANG_W'(half_s);
         cur_new_in  = ANG_W'(half_s - lock_off);
         turn_new_in = TURN_W'(maxr);
      end else if (total_raw < -half_s) begin
         total_in    = OUT_ANG_W'(-half_s);
         cur_new_in  = ANG_W'(lock_off - half_s);
         turn_new_in = -TURN_W'(maxr);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.angle)
         cur_ff <= cur_in;
      if (cmd.turn) begin
         total_ff    <= total_in;
         cur_new_ff  <= cur_new_in;
         turn_new_ff <= turn_new_in;
      end
   end

   // rounding divider: (2*v*32767 + den) / (2*den), one quotient bit a cycle
   always_comb begin
      v_full = TOT_W'(total_ff) + half_s;
      dsh    = (NUM_W + 1)'(dsr) << cmd.idx;
      rem_in = rem_ff;
      q_in   = q_ff;
      if (cmd.num) begin
         rem_in = (NUM_W'(v_full[V_W-1:0]) << 16) - (NUM_W'(v_full[V_W-1:0]) << 1)
                  + NUM_W'(dsr >> 1);
         q_in   = '0;
      end else if (cmd.div) begin
         if ({1'b0, rem_ff} >= dsh) begin
            rem_in = rem_ff - NUM_W'(dsh);
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   // wheel state
   assign axis_raw = dead ? held_ff : q_ff + AXIS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         turn_ff <= '0;
         held_ff <= HELD_RESET;
      end else if (cmd.done && !dead) begin
         prev_ff <= cur_new_ff;
         turn_ff <= turn_new_ff;
         held_ff <= axis_raw;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.done)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.done) begin
         axis_ff     <= invert_ff ? AXIS_W'((AXIS_W + 1)'(AXIS_MIRROR) - (AXIS_W + 1)'(axis_raw))
                                  : axis_raw;
         ang_out_ff  <= total_ff;
         turn_out_ff <= dead ? turn_ff : turn_new_ff;
         dead_out_ff <= dead;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_value   = axis_ff;
   assign rsp_wheel_angle  = ang_out_ff;
   assign rsp_turn_count   = turn_out_ff;
   assign rsp_deadzone_hit = dead_out_ff;

   `SMWA_CHECK_MSG(a_no_overwrite, cmd.done |-> (!rsp_valid_ff || rsp_ready), "smwa: lost rsp")
   `SMWA_CHECK(a_done_valid, cmd.done |=> rsp_valid_ff)
   `SMWA_CHECK(a_turn_range, (turn_ff <= TURN_W'(MAXR_N)) && (turn_ff >= -TURN_W'(MAXR_N)))
   `SMWA_CHECK(a_prev_range, (prev_ff <= ANG_W'(DEG180)) && (prev_ff >= -ANG_W'(DEG180)))

endmodule

>>> design/stick_to_multiturn_wheel_axis.sv
// ----------------------------------------------------------------------------
// stick_to_multiturn_wheel_axis
// Thumbstick sample to multi-turn steering wheel axis value.
// ----------------------------------------------------------------------------
// A sample in the dead zone skips the CORDIC and the divider, a stick on an
// axis skips only the 16-step CORDIC; all others run it and the 16-step divider.
// One transaction in flight; the next is accepted the cycle after the result
// is loaded into the response register.
// Reset (synchronous): range 900, no dead zone, no invert, angle and turns 0,
// held axis 16385 (centered).
module stick_to_multiturn_wheel_axis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [smwa_pkg::XY_W-1:0]      req_stick_x,
   input  logic signed [smwa_pkg::XY_W-1:0]      req_stick_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [smwa_pkg::AXIS_W-1:0]           rsp_axis_value,
   output logic signed [smwa_pkg::OUT_ANG_W-1:0] rsp_wheel_angle,
   output logic signed [smwa_pkg::TURN_W-1:0]    rsp_turn_count,
   output logic                                  rsp_deadzone_hit,
   input  logic                                  csr_we,
   input  logic [smwa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [smwa_pkg::CSR_DATA_W-1:0]       csr_data
);
   import smwa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   smwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic and state
   smwa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_stick_x      (req_stick_x),
      .req_stick_y      (req_stick_y),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_axis_value   (rsp_axis_value),
      .rsp_wheel_angle  (rsp_wheel_angle),
      .rsp_turn_count   (rsp_turn_count),
      .rsp_deadzone_hit (rsp_deadzone_hit)
   );

endmodule
